>>> hdl/linear_interp_resampler_assert.svh
// Assertion macros shared by the resampler RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lir_pkg.sv
package lir_pkg;

	// Fixed field and register widths.
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 24;
	localparam int LEN_W      = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Results per input item are capped; a counter of this width reaches the last slot.
	localparam int RES_CNT_W = 4;
	localparam logic [RES_CNT_W-1:0] RES_LAST = 4'd15;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUTS  = 2'd2;

	// Register values after reset.
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd1048576;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 21'd1;
	localparam logic [LEN_W-1:0]  MAX_RESET  = 21'd1048576;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic eval;
		logic emit;
	} lir_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_range;
		logic go;
		logic run_end;
		logic out_free;
	} lir_stat_t;

endpackage

>>> hdl/lir_ctrl.sv
module lir_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lir_pkg::lir_stat_t stat,
	output lir_pkg::lir_cmd_t  cmd
);
	import lir_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Commands and next state.
	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.eval   = 1'b0;
		cmd.emit   = 1'b0;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && stat.in_range) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.go ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.run_end ? ST_IDLE : ST_EVAL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/lir_datapath.sv
module lir_datapath #(
	parameter int MAX_LEN   = 1048576,
	parameter int FRAC_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lir_pkg::lir_cmd_t             cmd,
	output lir_pkg::lir_stat_t            stat,
	input  logic [lir_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic                          cfg_wr_en,
	input  logic [lir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                          out_run_end,
	output logic                          out_stream_end
);
	import lir_pkg::*;

	localparam int POS_W  = LEN_W + FRAC_BITS + 1;
	localparam int PROD_W = SAMPLE_W + 2 + FRAC_BITS;
	localparam int Q_W    = PROD_W - FRAC_BITS;
	localparam int LCMP_W = LEN_W + 4;
	localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(2 ** (FRAC_BITS - 3));
	localparam logic [LCMP_W-1:0] MAX_LEN_X = LCMP_W'(MAX_LEN);
	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(2 ** (FRAC_BITS - 1));

	// Configuration registers.
	logic [STEP_W-1:0] step_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  max_q;

	// Segment state.
	logic [SAMPLE_W-1:0] prev_q;
	logic [LEN_W-1:0]    inputs_q;
	logic [LEN_W-1:0]    outputs_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_plus_q;
	logic [RES_CNT_W-1:0] n_q;

	// Per-item operands.
	logic [SAMPLE_W-1:0]       base_q;
	logic signed [SAMPLE_W:0]  diff_q;
	logic [LEN_W-1:0]          k_q;
	logic                      final_q;

	// Evaluation stage.
	logic signed [PROD_W-1:0] prod_s1;
	logic                     sel_s1;
	logic                     run_end_s1;
	logic                     stream_end_s1;

	// Output register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_run_end_q;
	logic                out_stream_end_q;

	logic [STEP_W-1:0]        step_eff;
	logic [LEN_W-1:0]         len_eff;
	logic [POS_W-1:0]         len_fix;
	logic [POS_W-1:0]         k_fix;
	logic [POS_W:0]           pos_two;
	logic                     final_in;
	logic signed [SAMPLE_W:0] diff_in;
	logic                     interp_now;
	logic                     interp_next;
	logic                     cnt_ok;
	logic                     cnt_next_ok;
	logic                     room_ok;
	logic                     room_next_ok;
	logic signed [PROD_W-1:0] mul;
	logic signed [PROD_W-1:0] rounded;
	logic signed [Q_W-1:0]    q_val;
	logic [Q_W-1:0]           sum_val;
	logic [SAMPLE_W-1:0]      res_val;

	// Effective step and length after clamping.
	always_comb begin
		step_eff = (step_q < MIN_STEP) ? MIN_STEP : step_q;
		len_eff  = ({{(LCMP_W - LEN_W){1'b0}}, len_q} > MAX_LEN_X) ?
			MAX_LEN_X[LEN_W-1:0] : len_q;
		len_fix  = POS_W'({len_eff, {FRAC_BITS{1'b0}}});
		k_fix    = POS_W'({k_q, {FRAC_BITS{1'b0}}});
	end

	// Checks on an arriving beat.
	always_comb begin
		final_in = ({1'b0, inputs_q} + (LEN_W + 1)'(1)) == {1'b0, len_eff};
		diff_in  = $signed({in_sample[SAMPLE_W-1], in_sample}) -
			$signed({prev_q[SAMPLE_W-1], prev_q});
	end

	// Decision for the current output and a look-ahead for the one after it.
	always_comb begin
		pos_two      = {1'b0, pos_plus_q} + (POS_W + 1)'(step_eff);
		cnt_ok       = outputs_q < max_q;
		cnt_next_ok  = ({1'b0, outputs_q} + (LEN_W + 1)'(1)) < {1'b0, max_q};
		room_ok      = pos_plus_q <= len_fix;
		room_next_ok = pos_two <= {1'b0, len_fix};
		interp_now   = (k_q != '0) && (pos_q < k_fix);
		interp_next  = (k_q != '0) && (pos_plus_q < k_fix);
		mul          = $signed(diff_q) * $signed({1'b0, pos_q[FRAC_BITS-1:0]});
	end

	// Rounding to nearest, ties upward, then offset by the earlier sample.
	always_comb begin
		rounded = prod_s1 + HALF_LSB;
		q_val   = rounded[PROD_W-1:FRAC_BITS];
		sum_val = Q_W'($signed({{(Q_W - SAMPLE_W){base_q[SAMPLE_W-1]}}, base_q}) + q_val);
		res_val = sel_s1 ? sum_val[SAMPLE_W-1:0] : prev_q;
	end

	always_comb begin
		stat.in_range = inputs_q < len_eff;
		stat.go       = cnt_ok && room_ok && (interp_now || final_q);
		stat.run_end  = run_end_s1;
		stat.out_free = !out_valid_q || out_ready;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			len_q  <= LEN_RESET;
			max_q  <= MAX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STEP_RATIO:   step_q <= cfg_data[STEP_W-1:0];
				REG_INPUT_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
				REG_MAX_OUTPUTS:  max_q  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Segment state: counters, position and the previous sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			inputs_q   <= '0;
			outputs_q  <= '0;
			pos_q      <= '0;
			pos_plus_q <= '0;
			n_q        <= '0;
		end else if (cmd.accept && stat.in_range) begin
			prev_q     <= in_sample;
			inputs_q   <= inputs_q + LEN_W'(1);
			pos_plus_q <= pos_q + POS_W'(step_eff);
			n_q        <= '0;
		end else if (cmd.emit) begin
			outputs_q  <= outputs_q + LEN_W'(1);
			pos_q      <= pos_plus_q;
			pos_plus_q <= pos_plus_q + POS_W'(step_eff);
			n_q        <= n_q + RES_CNT_W'(1);
		end
	end

	// Operands held for the item being worked on.
	always_ff @(posedge clk) begin
		if (cmd.accept && stat.in_range) begin
			base_q  <= prev_q;
			diff_q  <= diff_in;
			k_q     <= inputs_q;
			final_q <= final_in;
		end
	end

	// Multiply and flags for one output.
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			prod_s1       <= mul;
			sel_s1        <= interp_now;
			stream_end_s1 <= !(cnt_next_ok && room_next_ok);
			run_end_s1    <= !(cnt_next_ok && room_next_ok) || (n_q == RES_LAST) ||
				!(interp_next || final_q);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q     <= res_val;
			out_run_end_q    <= run_end_s1;
			out_stream_end_q <= stream_end_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_sample     = out_sample_q;
	assign out_run_end    = out_run_end_q;
	assign out_stream_end = out_stream_end_q;

endmodule

>>> hdl/linear_interp_resampler.sv
// Linear-interpolation sample-rate converter.
// Input beats on s_* carry one signed Q1.15 sample each. Output beats on m_* carry
// interpolated Q1.15 samples; m_tlast marks the last output caused by one input
// sample and m_tuser marks the final output of the segment.
// The user writes step_ratio, input_length and max_outputs through cfg_* only while the
// block is idle; the block does not enforce it. They take effect with the next input beat.
// Sequence: an input beat is taken in the idle state; each result it causes then passes
// through an evaluate state, which compares positions and multiplies, and an emit state,
// which rounds and loads the output register (an item that gives no result still passes
// through the evaluate state). The first result appears on m_* once the emit state loads
// it. The single shared multiplier and its evaluate/emit loop handle one result at a time.
// While the receiver stalls, the finished result waits in the output register
// and the next result waits until it is taken; s_tready rises again as soon as
// the last result of an item is loaded, even if it has not been taken yet.
// Reset clears the segment state and restores the register reset values;
// inputs past the segment length are taken and give no output.
module linear_interp_resampler #(
	parameter int MAX_LEN   = 1048576,
	parameter int FRAC_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lir_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] in_sample
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lir_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] out_sample
	output logic                           m_tlast,
	output logic                           m_tuser,   // [0] stream_end
	input  logic                           cfg_wr_en,
	input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lir_pkg::*;

	lir_cmd_t  cmd;
	lir_stat_t stat;

	// Sequencer.
	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, segment state and output register.
	lir_datapath #(
		.MAX_LEN   (MAX_LEN),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_sample      (s_tdata),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_sample     (m_tdata),
		.out_run_end    (m_tlast),
		.out_stream_end (m_tuser)
	);

	`include "linear_interp_resampler_assert.svh"

	// A result is never loaded over one that has not been taken.
	`LIR_ASSERT_SAME(a_no_overwrite, cmd.emit, !m_tvalid || m_tready, "output overwritten")
	// The end of the segment always closes a run.
	`LIR_ASSERT_SAME(a_end_is_last, m_tvalid && m_tuser, m_tlast, "stream end without tlast")
	// An accepted sample inside the segment is evaluated in the next cycle.
	`LIR_ASSERT_NEXT(a_eval_follows, s_tvalid && s_tready && stat.in_range, cmd.eval,
		"accepted sample not evaluated")

endmodule
